/* sv/hsrd_pkg.sv */
// Shared types, constants and helper functions for the humidity sensor reading decoder.
`default_nettype none

package hsrd_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LOW_RES  = 2'd0;
  localparam logic [1:0] CFG_FAHR     = 2'd1;
  localparam logic [1:0] CFG_D1_OFFS  = 2'd2;

  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 17;

  localparam logic signed [16:0] D1_RESET = -17'sd39600;

  // Humidity coefficients, all scaled by 2^30.
  localparam int FracBits = 30;
  localparam logic signed [63:0] HUM_K1 = -64'sd2197734765363;
  localparam logic signed [63:0] HUM_K2 [2] = '{64'sd39406324941, 64'sd630501199053};
  localparam logic signed [63:0] HUM_K3 [2] = '{-64'sd1713155, -64'sd438569848};
  localparam logic signed [63:0] HUM_T1 = 64'sd10737418;
  localparam logic signed [63:0] HUM_T2 [2] = '{64'sd85899, 64'sd1374390};

  localparam logic signed [24:0] COMP_REF = 25'sd25000;
  localparam logic signed [33:0] HUM_MIN  = 34'sd100;
  localparam logic signed [33:0] HUM_MAX  = 34'sd100000;

  // Temperature slope in milli-degrees per code, indexed [low_resolution][fahrenheit].
  localparam logic [6:0] TEMP_D2 [2][2] = '{'{7'd10, 7'd18}, '{7'd40, 7'd72}};

  localparam logic [7:0] CRC_POLY = 8'h31;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_high;
    logic [7:0] data_low;
    logic [7:0] check_byte;
    logic       busy_bit;
  } reading_t;

  typedef struct packed {
    logic signed [23:0] value_milli;
    logic               error;
  } result_t;

  typedef struct packed {
    logic               low_resolution;
    logic               fahrenheit_unit;
    logic signed [16:0] temp_offset_milli;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CRC_HI,
    ST_CRC_LO,
    ST_TEMP,
    ST_HUM_1,
    ST_HUM_2,
    ST_HUM_3,
    ST_HUM_4,
    ST_HUM_5,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    MUL_K3_CODE,
    MUL_DT_T2,
    MUL_ACC_CODE,
    MUL_DT_T1,
    MUL_D2_CODE
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_K2,
    ACC_LOAD_K1,
    ACC_LOAD_D1,
    ACC_ADD_PROD
  } acc_op_t;

  typedef struct packed {
    logic     capture;
    logic     crc_hi;
    logic     crc_lo;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mode;
  } dp_status_t;

  // One byte of CRC-8, MSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/hsrd_ctrl.sv */
// Sequencing state machine for the humidity sensor reading decoder.
`default_nettype none

module hsrd_ctrl
  import hsrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_busy,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.crc_hi  = 1'b0;
    cmd.crc_lo  = 1'b0;
    cmd.mul_sel = MUL_K3_CODE;
    cmd.acc_op  = ACC_HOLD;
    cmd.finish  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = ST_CRC_HI;
        end
      end
      ST_CRC_HI: begin
        cmd.crc_hi = 1'b1;
        state_next = ST_CRC_LO;
      end
      ST_CRC_LO: begin
        cmd.crc_lo = 1'b1;
        if (status.mode) begin
          cmd.mul_sel = MUL_K3_CODE;
          state_next  = ST_HUM_1;
        end else begin
          cmd.mul_sel = MUL_D2_CODE;
          state_next  = ST_TEMP;
        end
      end
      ST_TEMP: begin
        cmd.acc_op = ACC_LOAD_D1;
        state_next = ST_FINISH;
      end
      ST_HUM_1: begin
        cmd.acc_op  = ACC_LOAD_K2;
        cmd.mul_sel = MUL_DT_T2;
        state_next  = ST_HUM_2;
      end
      ST_HUM_2: begin
        cmd.acc_op = ACC_ADD_PROD;
        state_next = ST_HUM_3;
      end
      ST_HUM_3: begin
        cmd.mul_sel = MUL_ACC_CODE;
        state_next  = ST_HUM_4;
      end
      ST_HUM_4: begin
        cmd.acc_op  = ACC_LOAD_K1;
        cmd.mul_sel = MUL_DT_T1;
        state_next  = ST_HUM_5;
      end
      ST_HUM_5: begin
        cmd.acc_op = ACC_ADD_PROD;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/hsrd_dp.sv */
// Datapath of the humidity sensor reading decoder: CRC, shared multiplier, accumulator.
`default_nettype none

module hsrd_dp
  import hsrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  reading_t   in_data,
  input  cfg_t       cfg,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output result_t    result
);

  reading_t           item;
  logic [7:0]         crc;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [63:0] acc_next;
  logic signed [23:0] last_temp;

  logic [15:0]        code;
  logic signed [24:0] dt;
  logic signed [47:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [72:0] prod_full;
  logic               err;
  logic signed [33:0] hum_q;
  logic signed [33:0] hum_clamped;
  logic               r;

  assign code = {item.data_high, item.data_low};
  assign r    = cfg.low_resolution;
  assign dt   = {last_temp[23], last_temp} - COMP_REF;

  always_comb begin
    mul_a = 48'sd0;
    mul_b = 25'sd0;
    case (cmd.mul_sel)
      MUL_K3_CODE: begin
        mul_a = HUM_K3[r][47:0];
        mul_b = {9'd0, code};
      end
      MUL_DT_T2: begin
        mul_a = HUM_T2[r][47:0];
        mul_b = dt;
      end
      MUL_ACC_CODE: begin
        mul_a = acc[47:0];
        mul_b = {9'd0, code};
      end
      MUL_DT_T1: begin
        mul_a = HUM_T1[47:0];
        mul_b = dt;
      end
      MUL_D2_CODE: begin
        mul_a = {41'd0, TEMP_D2[r][cfg.fahrenheit_unit]};
        mul_b = {9'd0, code};
      end
      default: begin
        mul_a = 48'sd0;
        mul_b = 25'sd0;
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;

  always_comb begin
    case (cmd.acc_op)
      ACC_LOAD_K2:  acc_next = HUM_K2[r] + prod;
      ACC_LOAD_K1:  acc_next = HUM_K1 + prod;
      ACC_LOAD_D1:  acc_next = {{47{cfg.temp_offset_milli[16]}}, cfg.temp_offset_milli} + prod;
      ACC_ADD_PROD: acc_next = acc + prod;
      default:      acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
    end
    if (cmd.crc_hi) begin
      crc <= crc8_byte(8'h00, item.data_high);
    end else if (cmd.crc_lo) begin
      crc <= crc8_byte(crc, item.data_low);
    end
    prod <= prod_full[63:0];
    acc  <= acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_temp <= 24'sd0;
    end else if (cmd.finish && !item.mode) begin
      last_temp <= result.value_milli;
    end
  end

  assign err = item.busy_bit | (crc != item.check_byte);

  // Arithmetic shift gives the floor of the scaled sum.
  assign hum_q = acc[63:FracBits];

  always_comb begin
    if (hum_q > HUM_MAX) begin
      hum_clamped = HUM_MAX;
    end else if (hum_q < HUM_MIN) begin
      hum_clamped = HUM_MIN;
    end else begin
      hum_clamped = hum_q;
    end
  end

  always_comb begin
    result.error = err;
    if (err) begin
      result.value_milli = 24'sd0;
    end else if (item.mode) begin
      result.value_milli = hum_clamped[23:0];
    end else begin
      result.value_milli = acc[23:0];
    end
  end

  assign status.mode = item.mode;

endmodule

`default_nettype wire

/* sv/humidity_sensor_reading_decode_core.sv */
// Top level of the humidity sensor reading decoder.
//
// Each input transaction carries one sensor reading: a mode bit (0 temperature,
// 1 humidity), the two raw data bytes, the sensor's CRC-8 check byte and the busy
// bit. The block checks the CRC (polynomial 0x31, initial value 0, high byte first)
// and flags an error when the CRC fails or the busy bit is set; the value is then
// zero. A temperature reading gives d1 + d2 * code in milli-degrees and becomes the
// stored temperature used to compensate later humidity readings; an erroneous
// temperature reading stores zero. A humidity reading gives a temperature
// compensated quadratic in milli-%RH, floored and clamped to 100..100000. Every
// reading produces exactly one output transaction. Readings are processed one at a
// time by a state machine driving a single shared 48 x 25 bit multiplier. The time
// from acceptance until the block is ready again is set by the CRC steps plus the
// chain of dependent multiply and accumulate steps through that multiplier, and is
// longer for a humidity reading than for a temperature reading. The result sits
// in an output register, so a new reading is accepted while the previous result is
// still waiting; the sequencer only stalls at its last step if that register is
// still occupied. Configuration registers (resolution, Fahrenheit, d1 offset) are
// written through cfg_write, cfg_index and cfg_data and should only change while
// the block is idle.
`default_nettype none

module humidity_sensor_reading_decode_core
  import hsrd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  reading_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output result_t              out_data,
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  result_t    result;
  logic       out_busy;

  // Configuration registers. Writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_resolution    <= 1'b0;
      cfg.fahrenheit_unit   <= 1'b0;
      cfg.temp_offset_milli <= D1_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LOW_RES: cfg.low_resolution    <= cfg_data[0];
        CFG_FAHR:    cfg.fahrenheit_unit   <= cfg_data[0];
        CFG_D1_OFFS: cfg.temp_offset_milli <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The output register is busy when it holds a result that is not taken this cycle.
  assign out_busy = out_valid & ~out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= result;
    end
  end

  hsrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_busy (out_busy),
    .status   (status),
    .cmd      (cmd)
  );

  hsrd_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_data (in_data),
    .cfg     (cfg),
    .cmd     (cmd),
    .status  (status),
    .result  (result)
  );

endmodule

`default_nettype wire
